@@ rtl/core/eqf_pkg.sv @@
// shared types, constants and command codes of the qrs enhancement filter
package eqf_pkg;

  localparam int DIFF_LEN       = 12;
  localparam int DIFF_HALF      = DIFF_LEN / 2;
  localparam int MAX_WINDOW     = 1024;
  localparam int WIN_AW         = $clog2(MAX_WINDOW);
  localparam int WIN_CW         = WIN_AW + 1;
  localparam int MAX_GAIN_DELAY = 64;
  localparam int GD_AW          = $clog2(MAX_GAIN_DELAY);
  localparam int MAX_ORDER      = 8;
  localparam int PO_AW          = $clog2(MAX_ORDER);
  localparam int MAX_AVERAGE    = 64;
  localparam int AV_AW          = $clog2(MAX_AVERAGE);

  localparam int SAMPLE_W = 16;
  localparam int VAL_W    = 31;
  localparam int STAMP_W  = 32;
  localparam int SUM_W    = 38;
  localparam int DIVS_W   = 16;
  localparam int DIVD_W   = DIVS_W + VAL_W;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int DQ_W     = STAMP_W + DIVS_W;

  localparam logic [VAL_W-1:0] SAT31 = '1;

  typedef enum logic [2:0] {
    REG_MAX_WINDOW,
    REG_GAIN_DELAY,
    REG_PRODUCT_ORDER,
    REG_GAIN_CEILING,
    REG_GAIN_FLOOR,
    REG_AVERAGE_LENGTH,
    REG_AVERAGE_SHIFT
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] max_window;
    logic [6:0]  gain_delay;
    logic [3:0]  product_order;
    logic [30:0] gain_ceiling;
    logic [14:0] gain_floor;
    logic [6:0]  average_length;
    logic [2:0]  average_shift;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_HEAD,
    OP_POP_FRONT,
    OP_RD_TAIL,
    OP_POP_BACK,
    OP_PUSH,
    OP_HEAD,
    OP_MUL,
    OP_DIV_START,
    OP_PROD_WR,
    OP_PROD_MUL,
    OP_PROD_SAT,
    OP_AVG_RD,
    OP_AVG_SUM,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic empty;
    logic expired;
    logic dominated;
    logic div_busy;
    logic prod_last;
  } dp_status_t;

endpackage

@@ rtl/core/ecg_qrs_enhancement_filter_top.sv @@
// Top level of the ECG QRS enhancement filter. Each accepted transaction carries one signed
// 16-bit sample and yields one 31-bit detection value, in order. Samples are processed one at
// a time: each item waits on the bit-serial divider of the gain control and runs the product
// loop over m factors, where m is the product order, and each deque entry evicted costs one
// memory read and one compare. The next sample is taken as soon as the previous one reaches
// the output register, even while that result still waits on out_stall. Registers sit at
// byte addresses 4*i and should only be written while the block is idle.
module ecg_qrs_enhancement_filter_top import eqf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_ecg_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [VAL_W-1:0]           out_detection_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  cfg_t       cfg;
  op_t        op;
  dp_status_t st;

  eqf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .op        (op)
  );

  eqf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .cfg       (cfg),
    .in_sample (in_ecg_sample),
    .st        (st),
    .out_data  (out_detection_value)
  );

endmodule

@@ rtl/core/eqf_cfg.sv @@
// configuration register file with apb-style access
module eqf_cfg import eqf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_window     <= 11'd720;
      cfg_r.gain_delay     <= 7'd18;
      cfg_r.product_order  <= 4'd3;
      cfg_r.gain_ceiling   <= 31'd1023;
      cfg_r.gain_floor     <= 15'd8;
      cfg_r.average_length <= 7'd37;
      cfg_r.average_shift  <= 3'd6;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_WINDOW:     cfg_r.max_window     <= pwdata[10:0];
        REG_GAIN_DELAY:     cfg_r.gain_delay     <= pwdata[6:0];
        REG_PRODUCT_ORDER:  cfg_r.product_order  <= pwdata[3:0];
        REG_GAIN_CEILING:   cfg_r.gain_ceiling   <= pwdata[30:0];
        REG_GAIN_FLOOR:     cfg_r.gain_floor     <= pwdata[14:0];
        REG_AVERAGE_LENGTH: cfg_r.average_length <= pwdata[6:0];
        REG_AVERAGE_SHIFT:  cfg_r.average_shift  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_WINDOW:     prdata = {21'b0, cfg_r.max_window};
      REG_GAIN_DELAY:     prdata = {25'b0, cfg_r.gain_delay};
      REG_PRODUCT_ORDER:  prdata = {28'b0, cfg_r.product_order};
      REG_GAIN_CEILING:   prdata = {1'b0, cfg_r.gain_ceiling};
      REG_GAIN_FLOOR:     prdata = {17'b0, cfg_r.gain_floor};
      REG_AVERAGE_LENGTH: prdata = {25'b0, cfg_r.average_length};
      REG_AVERAGE_SHIFT:  prdata = {29'b0, cfg_r.average_shift};
      default:            prdata = 32'b0;
    endcase
  end

endmodule

@@ rtl/core/eqf_div.sv @@
// restoring divider, one quotient bit per cycle
module eqf_div import eqf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVS_W:0]   rem_sh;
  logic              q_bit;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIVD_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_r});
    if (q_bit) begin
      rem_nxt = DIVS_W'(rem_sh - {1'b0, dvs_r});
    end else begin
      rem_nxt = rem_sh[DIVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVD_W-2:0], q_bit};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/eqf_dp.sv @@
// datapath: difference, max deque, gain control, product and moving sum
module eqf_dp import eqf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  op_t                        op,
  input  cfg_t                       cfg,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output dp_status_t                 st,
  output logic [VAL_W-1:0]           out_data
);

  // second difference
  logic signed [SAMPLE_W-1:0] sh_r [DIFF_LEN];
  logic signed [SAMPLE_W+1:0] y;
  logic signed [SAMPLE_W-1:0] q;
  logic [SAMPLE_W-1:0]        a_nxt, a_r;

  assign y = {{2{in_sample[SAMPLE_W-1]}}, in_sample}
           - {sh_r[DIFF_HALF-1][SAMPLE_W-1], sh_r[DIFF_HALF-1], 1'b0}
           + {{2{sh_r[DIFF_LEN-1][SAMPLE_W-1]}}, sh_r[DIFF_LEN-1]};
  assign q     = y[SAMPLE_W+1:2];
  assign a_nxt = q[SAMPLE_W-1] ? SAMPLE_W'(~q + 1'b1) : q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIFF_LEN; i++) sh_r[i] <= '0;
    end else if (op == OP_LOAD) begin
      sh_r[0] <= in_sample;
      for (int i = 1; i < DIFF_LEN; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) a_r <= a_nxt;
  end

  // sliding maximum deque
  logic [WIN_CW-1:0]  w_c;
  logic [WIN_AW-1:0]  head_r, tail_addr, push_addr, rd_addr;
  logic [WIN_CW-1:0]  cnt_r;
  logic [STAMP_W-1:0] ctr_r, age;
  logic [DQ_W-1:0]    dq_mem_r [MAX_WINDOW];
  logic [DQ_W-1:0]    dq_q_r;
  logic [DIVS_W-1:0]  dq_val;
  logic               dq_rd;

  assign w_c = (cfg.max_window == '0) ? WIN_CW'(1)
             : (cfg.max_window > WIN_CW'(MAX_WINDOW)) ? WIN_CW'(MAX_WINDOW)
             : cfg.max_window;
  assign tail_addr = head_r + cnt_r[WIN_AW-1:0] - WIN_AW'(1);
  assign push_addr = head_r + cnt_r[WIN_AW-1:0];
  assign rd_addr   = (op == OP_RD_TAIL) ? tail_addr : head_r;
  assign dq_rd     = (op == OP_RD_HEAD) || (op == OP_RD_TAIL) || (op == OP_HEAD);
  assign dq_val    = dq_q_r[DIVS_W-1:0];
  assign age       = ctr_r - dq_q_r[DQ_W-1:DIVS_W];

  always_ff @(posedge clk) begin
    if (op == OP_PUSH) dq_mem_r[push_addr] <= {ctr_r, a_r};
  end

  always_ff @(posedge clk) begin
    if (dq_rd) dq_q_r <= dq_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
      ctr_r  <= '0;
    end else begin
      case (op)
        OP_POP_FRONT: begin
          head_r <= head_r + WIN_AW'(1);
          cnt_r  <= cnt_r - WIN_CW'(1);
        end
        OP_POP_BACK: cnt_r <= cnt_r - WIN_CW'(1);
        OP_PUSH: begin
          cnt_r <= cnt_r + WIN_CW'(1);
          ctr_r <= ctr_r + STAMP_W'(1);
        end
        default: ;
      endcase
    end
  end

  // gain delay line
  logic [GD_AW:0]     d_c;
  logic [GD_AW-1:0]   gidx_r, gi, gnext;
  logic [DIVS_W-1:0]  gmem_r [MAX_GAIN_DELAY];
  logic [MAX_GAIN_DELAY-1:0] gvld_r;
  logic [DIVS_W-1:0]  gh_q_r, gh_val;
  logic               gv_q_r;

  assign d_c = (cfg.gain_delay == '0) ? (GD_AW+1)'(1)
             : (cfg.gain_delay > (GD_AW+1)'(MAX_GAIN_DELAY)) ? (GD_AW+1)'(MAX_GAIN_DELAY)
             : cfg.gain_delay;
  assign gi     = ({1'b0, gidx_r} >= d_c) ? '0 : gidx_r;
  assign gnext  = ({1'b0, gi} + (GD_AW+1)'(1) >= d_c) ? '0 : gi + GD_AW'(1);
  assign gh_val = gv_q_r ? gh_q_r : '0;

  always_ff @(posedge clk) begin
    if (op == OP_HEAD) begin
      gh_q_r     <= gmem_r[gi];
      gmem_r[gi] <= a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gidx_r <= '0;
      gvld_r <= '0;
      gv_q_r <= 1'b0;
    end else if (op == OP_HEAD) begin
      gv_q_r     <= gvld_r[gi];
      gvld_r[gi] <= 1'b1;
      gidx_r     <= gnext;
    end
  end

  // scale by ceiling over max(gain, floor)
  logic [DIVS_W-1:0] fl, dvs_nxt, dvs_r;
  logic [DIVD_W-1:0] dvd_r, quo;
  logic [VAL_W-1:0]  gv;
  logic              div_busy;

  assign fl      = (cfg.gain_floor == '0) ? DIVS_W'(1) : {1'b0, cfg.gain_floor};
  assign dvs_nxt = (dq_val > fl) ? dq_val : fl;

  always_ff @(posedge clk) begin
    if (op == OP_MUL) begin
      dvd_r <= gh_val * cfg.gain_ceiling;
      dvs_r <= dvs_nxt;
    end
  end

  eqf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (op == OP_DIV_START),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign gv = (quo > DIVD_W'(cfg.gain_ceiling)) ? cfg.gain_ceiling : quo[VAL_W-1:0];

  // product over the last m gain outputs
  logic [PO_AW:0]    m_c;
  logic [PO_AW-1:0]  pidx_r, pi, pnext, k_r;
  logic [VAL_W-1:0]  ph_r [MAX_ORDER];
  logic [VAL_W-1:0]  p_r;
  logic [PROD_W-1:0] mul_r;

  assign m_c = (cfg.product_order == '0) ? (PO_AW+1)'(1)
             : (cfg.product_order > (PO_AW+1)'(MAX_ORDER)) ? (PO_AW+1)'(MAX_ORDER)
             : cfg.product_order;
  assign pi    = ({1'b0, pidx_r} >= m_c) ? '0 : pidx_r;
  assign pnext = ({1'b0, pi} + (PO_AW+1)'(1) >= m_c) ? '0 : pi + PO_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ORDER; i++) ph_r[i] <= VAL_W'(1);
      pidx_r <= '0;
    end else if (op == OP_PROD_WR) begin
      ph_r[pi] <= gv;
      pidx_r   <= pnext;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_PROD_WR: begin
        p_r <= VAL_W'(1);
        k_r <= '0;
      end
      OP_PROD_MUL: mul_r <= p_r * ph_r[k_r];
      OP_PROD_SAT: begin
        p_r <= (mul_r > PROD_W'(SAT31)) ? SAT31 : mul_r[VAL_W-1:0];
        k_r <= k_r + PO_AW'(1);
      end
      default: ;
    endcase
  end

  // moving sum
  logic [AV_AW:0]     len_c;
  logic [AV_AW-1:0]   aidx_r, ai, anext;
  logic [VAL_W-1:0]   amem_r [MAX_AVERAGE];
  logic [MAX_AVERAGE-1:0] avld_r;
  logic [VAL_W-1:0]   ah_q_r, old_val;
  logic               av_q_r;
  logic [SUM_W-1:0]   sum_r, shifted;
  logic [VAL_W-1:0]   out_r;

  assign len_c = (cfg.average_length == '0) ? (AV_AW+1)'(1)
               : (cfg.average_length > (AV_AW+1)'(MAX_AVERAGE)) ? (AV_AW+1)'(MAX_AVERAGE)
               : cfg.average_length;
  assign ai      = ({1'b0, aidx_r} >= len_c) ? '0 : aidx_r;
  assign anext   = ({1'b0, ai} + (AV_AW+1)'(1) >= len_c) ? '0 : ai + AV_AW'(1);
  assign old_val = av_q_r ? ah_q_r : '0;
  assign shifted = sum_r >> cfg.average_shift;

  always_ff @(posedge clk) begin
    if (op == OP_AVG_RD) begin
      ah_q_r     <= amem_r[ai];
      amem_r[ai] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aidx_r <= '0;
      avld_r <= '0;
      av_q_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      case (op)
        OP_AVG_RD: begin
          av_q_r     <= avld_r[ai];
          avld_r[ai] <= 1'b1;
          aidx_r     <= anext;
        end
        OP_AVG_SUM: sum_r <= sum_r - SUM_W'(old_val) + SUM_W'(p_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_r <= (shifted > SUM_W'(SAT31)) ? SAT31 : shifted[VAL_W-1:0];
    end
  end

  assign out_data     = out_r;
  assign st.empty     = (cnt_r == '0);
  assign st.expired   = (age >= STAMP_W'(w_c));
  assign st.dominated = (a_r >= dq_val);
  assign st.div_busy  = div_busy;
  assign st.prod_last = ({1'b0, k_r} == m_c - (PO_AW+1)'(1));

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= WIN_CW'(MAX_WINDOW))
    else $error("deque holds more entries than the window");

  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_PUSH) |=> (cnt_r != '0))
    else $error("deque empty after push");

  a_prod_index: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_PROD_SAT) |-> ({1'b0, k_r} < m_c))
    else $error("product loop ran past the order");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_DIV_START) |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

@@ rtl/core/eqf_ctrl.sv @@
// sequencer for one sample through the filter chain
module eqf_ctrl import eqf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t st,
  output op_t        op
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FR_RD,
    S_FR_EV,
    S_BK_RD,
    S_BK_EV,
    S_PUSH,
    S_HEAD,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PROD_WR,
    S_PROD_MUL,
    S_PROD_SAT,
    S_AVG_RD,
    S_AVG_SUM,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_FR_RD;
        end
      end
      S_FR_RD: begin
        if (st.empty) begin
          state_nxt = S_BK_RD;
        end else begin
          op        = OP_RD_HEAD;
          state_nxt = S_FR_EV;
        end
      end
      S_FR_EV: begin
        if (st.expired) begin
          op        = OP_POP_FRONT;
          state_nxt = S_FR_RD;
        end else begin
          state_nxt = S_BK_RD;
        end
      end
      S_BK_RD: begin
        if (st.empty) begin
          state_nxt = S_PUSH;
        end else begin
          op        = OP_RD_TAIL;
          state_nxt = S_BK_EV;
        end
      end
      S_BK_EV: begin
        if (st.dominated) begin
          op        = OP_POP_BACK;
          state_nxt = S_BK_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        op        = OP_PUSH;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        op        = OP_HEAD;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        op        = OP_MUL;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        op        = OP_DIV_START;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!st.div_busy) state_nxt = S_PROD_WR;
      end
      S_PROD_WR: begin
        op        = OP_PROD_WR;
        state_nxt = S_PROD_MUL;
      end
      S_PROD_MUL: begin
        op        = OP_PROD_MUL;
        state_nxt = S_PROD_SAT;
      end
      S_PROD_SAT: begin
        op        = OP_PROD_SAT;
        state_nxt = st.prod_last ? S_AVG_RD : S_PROD_MUL;
      end
      S_AVG_RD: begin
        op        = OP_AVG_RD;
        state_nxt = S_AVG_SUM;
      end
      S_AVG_SUM: begin
        op        = OP_AVG_SUM;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ tb/tb.sv @@
// testbench for ecg_qrs_enhancement_filter_top: directed, config-sweep and random sample streams
`timescale 1ns / 100ps
module tb;
  import eqf_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_ecg_sample;
  logic out_valid;
  logic out_stall;
  logic [VAL_W-1:0] out_detection_value;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  ecg_qrs_enhancement_filter_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_ecg_sample(in_ecg_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_detection_value(out_detection_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor configuration
  logic [10:0] c_window;
  logic [6:0]  c_delay;
  logic [3:0]  c_order;
  logic [30:0] c_ceiling;
  logic [14:0] c_floor;
  logic [6:0]  c_avg_len;
  logic [2:0]  c_avg_shift;

  // predictor state
  logic [15:0] diff_buf [DIFF_LEN];
  int unsigned diff_ptr;
  logic [15:0] dq_val [MAX_WINDOW];
  logic [31:0] dq_stamp [MAX_WINDOW];
  int unsigned dq_head, dq_count;
  logic [31:0] sample_count;
  logic [15:0] delay_line [MAX_GAIN_DELAY];
  int unsigned delay_ptr;
  logic [30:0] factors [MAX_ORDER];
  int unsigned factor_ptr;
  logic [30:0] avg_buf [MAX_AVERAGE];
  int unsigned avg_ptr;
  logic [63:0] avg_sum;

  logic [VAL_W-1:0] expected_detections [$];
  int errors;
  int samples_sent;
  int detections_seen;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d detections outstanding", expected_detections.size());
    $display("ecg_qrs_enhancement_filter_top verification failed");
    $finish;
  end

  function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  task automatic reset_predictor();
    c_window = 720; c_delay = 18; c_order = 3; c_ceiling = 1023;
    c_floor = 8; c_avg_len = 37; c_avg_shift = 6;
    foreach (diff_buf[k]) diff_buf[k] = '0;
    foreach (delay_line[k]) delay_line[k] = '0;
    foreach (factors[k]) factors[k] = 31'd1;
    foreach (avg_buf[k]) avg_buf[k] = '0;
    diff_ptr = 0; dq_head = 0; dq_count = 0; sample_count = '0;
    delay_ptr = 0; factor_ptr = 0; avg_ptr = 0; avg_sum = '0;
  endtask

  // whole chain for one sample: second difference, running max, agc, product, moving sum
  function automatic logic [VAL_W-1:0] predict_detection(logic signed [15:0] x);
    int unsigned mid, w, tail, pos, d, fl, g, m, len;
    int signed y, q;
    logic [15:0] mag, gain;
    logic [63:0] scaled, prod, shifted;
    logic [30:0] agc;

    mid = (diff_ptr + DIFF_HALF) % DIFF_LEN;
    y = int'(x) - 2 * int'($signed(diff_buf[mid])) + int'($signed(diff_buf[diff_ptr]));
    q = y >>> 2;
    mag = (q < 0) ? 16'(-q) : 16'(q);
    diff_buf[diff_ptr] = x;
    diff_ptr = (diff_ptr + 1 == DIFF_LEN) ? 0 : diff_ptr + 1;

    w = clamp_len(c_window, MAX_WINDOW);
    while (dq_count > 0 && (sample_count - dq_stamp[dq_head]) >= w) begin
      dq_head = (dq_head + 1) % MAX_WINDOW;
      dq_count--;
    end
    while (dq_count > 0) begin
      tail = (dq_head + dq_count - 1) % MAX_WINDOW;
      if (mag >= dq_val[tail]) dq_count--;
      else break;
    end
    pos = (dq_head + dq_count) % MAX_WINDOW;
    dq_val[pos] = mag;
    dq_stamp[pos] = sample_count;
    dq_count++;
    sample_count++;
    gain = dq_val[dq_head];

    d = clamp_len(c_delay, MAX_GAIN_DELAY);
    fl = (c_floor == 0) ? 1 : c_floor;
    g = (gain > fl) ? gain : fl;
    if (delay_ptr >= d) delay_ptr = 0;
    scaled = (64'(delay_line[delay_ptr]) * 64'(c_ceiling)) / 64'(g);
    delay_line[delay_ptr] = mag;
    delay_ptr = (delay_ptr + 1 >= d) ? 0 : delay_ptr + 1;
    agc = (scaled > 64'(c_ceiling)) ? c_ceiling : scaled[30:0];

    m = clamp_len(c_order, MAX_ORDER);
    if (factor_ptr >= m) factor_ptr = 0;
    factors[factor_ptr] = agc;
    factor_ptr = (factor_ptr + 1 >= m) ? 0 : factor_ptr + 1;
    prod = 64'd1;
    for (int k = 0; k < m; k++) begin
      prod = prod * 64'(factors[k]);
      if (prod > 64'(SAT31)) prod = 64'(SAT31);
    end

    len = clamp_len(c_avg_len, MAX_AVERAGE);
    if (avg_ptr >= len) avg_ptr = 0;
    avg_sum = avg_sum - 64'(avg_buf[avg_ptr]) + prod;
    avg_buf[avg_ptr] = prod[30:0];
    avg_ptr = (avg_ptr + 1 >= len) ? 0 : avg_ptr + 1;
    shifted = avg_sum >> c_avg_shift;
    return (shifted > 64'(SAT31)) ? SAT31 : shifted[30:0];
  endfunction

  // called at a rising edge; returns after acceptance and any random idle gap that follows
  task automatic send_sample(logic signed [15:0] x);
    int gap;
    in_valid <= 1'b1;
    in_ecg_sample <= x;
    do @(posedge clk); while (in_stall);
    expected_detections.push_back(predict_detection(x));
    samples_sent++;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(12, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_detections.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAX_WINDOW:     c_window = val[10:0];
      REG_GAIN_DELAY:     c_delay = val[6:0];
      REG_PRODUCT_ORDER:  c_order = val[3:0];
      REG_GAIN_CEILING:   c_ceiling = val[30:0];
      REG_GAIN_FLOOR:     c_floor = val[14:0];
      REG_AVERAGE_LENGTH: c_avg_len = val[6:0];
      REG_AVERAGE_SHIFT:  c_avg_shift = val[2:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] win, logic [31:0] dly, logic [31:0] ord,
                           logic [31:0] ceil_v, logic [31:0] flr, logic [31:0] alen,
                           logic [31:0] ash);
    write_reg(REG_MAX_WINDOW, win);
    write_reg(REG_GAIN_DELAY, dly);
    write_reg(REG_PRODUCT_ORDER, ord);
    write_reg(REG_GAIN_CEILING, ceil_v);
    write_reg(REG_GAIN_FLOOR, flr);
    write_reg(REG_AVERAGE_LENGTH, alen);
    write_reg(REG_AVERAGE_SHIFT, ash);
  endtask

  // beat-like shapes for half the draws, otherwise full-range or small noise
  function automatic logic signed [15:0] random_sample(int n);
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return 16'($urandom);
    if (sel < 5) return 16'($signed($urandom_range(400)) - 200);
    if (n % 40 < 4) return 16'($signed($urandom_range(32767)) - (n % 2) * 32768);
    return 16'(int'(n % 40) * 150 - 3000 + $signed($urandom_range(100)));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      detections_seen++;
      if (expected_detections.size() == 0) begin
        report_mismatch($sformatf("detection %0d with none expected", out_detection_value));
      end else begin
        if (out_detection_value !== expected_detections[0])
          report_mismatch($sformatf("detection_value got %0d expected %0d",
                                    out_detection_value, expected_detections[0]));
        void'(expected_detections.pop_front());
      end
    end
  end

  task automatic test_directed_extremes();
    logic signed [15:0] pat [14] = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 0, 0,
                                     16'sh7FFF, 16'sh7FFF, -16'sh8000, 1, -1, 16'sh5555,
                                     16'shAAAA, 0};
    foreach (pat[k]) send_sample(pat[k]);
    for (int k = 0; k < 8; k++) send_sample(16'(k * 4000 - 16000));
    wait_drained();
  endtask

  task automatic test_config_corners();
    // lowest legal settings
    write_all(1, 1, 1, 1, 1, 1, 0);
    for (int k = 0; k < 20; k++) send_sample(random_sample(k));
    wait_drained();
    // highest legal settings, apart from an average shift of 6
    write_all(1024, 64, 8, 32'h7FFF_FFFF, 32767, 64, 6);
    for (int k = 0; k < 40; k++) send_sample(random_sample(k));
    wait_drained();
    // zeros and beyond-range codes
    write_all(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 7);
    for (int k = 0; k < 20; k++) send_sample(random_sample(k));
    wait_drained();
    write_all(2047, 127, 15, 32'hFFFF_FFFF, 32'h7FFF, 127, 0);
    for (int k = 0; k < 40; k++) send_sample(random_sample(k));
    wait_drained();
    // shrink the window and averages with history still held
    write_all(3, 2, 2, 5000, 2, 5, 2);
    for (int k = 0; k < 20; k++) send_sample(random_sample(k));
    wait_drained();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_p, int count);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    write_all($urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(8, 1),
              $urandom_range(1 << 20, 1), $urandom_range(300, 1), $urandom_range(64, 1),
              $urandom_range(6));
    if ($urandom_range(3) == 0) write_reg(REG_MAX_WINDOW, $urandom_range(1024, 1));
    for (int k = 0; k < count; k++) send_sample(random_sample(k));
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 600;
    for (int k = 0; k < 30; k++) send_sample(random_sample(k));
    wait_drained();
    // decreasing ramp with a constant second difference, then a full-scale positive and negative spike
    write_all(1024, 5, 2, 1023, 8, 10, 3);
    for (int k = 0; k < 60; k++) send_sample(16'(30000 - k * 500));
    send_sample(16'sh7FFF);
    send_sample(-16'sh8000);
    wait_drained();
  endtask

  initial begin
    errors = 0; samples_sent = 0; detections_seen = 0;
    send_idle_pct = 0; stall_pct = 0; hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_ecg_sample = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_config_corners();
    test_random_phase(0, 0, 120);
    test_random_phase(87, 0, 120);
    test_random_phase(0, 87, 120);
    test_random_phase(21, 21, 120);
    test_random_phase(0, 0, 120);
    test_random_phase(87, 87, 100);
    test_backpressure();

    repeat (200) @(posedge clk);
    $display("covered %0d samples, %0d detections, register corners and random settings",
             samples_sent, detections_seen);
    $display("idle and stall mixes plus a long output hold were exercised");
    if (errors == 0 && expected_detections.size() == 0) begin
      $display("ecg_qrs_enhancement_filter_top verification clean");
    end else begin
      $display("ecg_qrs_enhancement_filter_top verification failed");
    end
    $finish;
  end

endmodule
